>>> sv/mbe_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Shared widths, configuration register indexes, reset values and the
// payload types of the pixel and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package mbe_pkg;

  // Pixel coordinates and frame extents are this wide.
  localparam int COORD_BITS = 12;
  // Iteration limit register width.
  localparam int LIMIT_BITS = 8;
  // Escape count field width: the limit plus one more.
  localparam int COUNT_BITS = LIMIT_BITS + 1;
  // Default number of fraction bits of the fixed-point values.
  localparam int FRAC_BITS_DEF = 28;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = COORD_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ITERATION_LIMIT = 2'd2;

  localparam logic [COORD_BITS-1:0] FRAME_WIDTH_RST     = 12'd2000;
  localparam logic [COORD_BITS-1:0] FRAME_HEIGHT_RST    = 12'd2000;
  localparam logic [LIMIT_BITS-1:0] ITERATION_LIMIT_RST = 8'd100;

  // Divider widths at the default fraction width.
  localparam int DIV_DVD_BITS_DEF = COORD_BITS + 1 + FRAC_BITS_DEF;
  localparam int DIV_DVS_BITS_DEF = COORD_BITS + 1;

  // One pixel position.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
  } pixel_t;

  // One escape-time result.
  typedef struct packed {
    logic                  escaped;
    logic [COUNT_BITS-1:0] escape_count;
  } result_t;

endpackage

`default_nettype wire

>>> sv/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Maps a pixel to a complex constant and counts z = z^2 + c iterations until
// |z|^2 > 4, a part of the new z leaves [-2, 2] or the iteration limit is reached.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel (column, row) transfers on the input channel when in_valid_i is
//   high and in_stall_o is low. Exactly one result transfers on the output
//   channel for every pixel, when out_valid_o is high and out_stall_i low.
//   The block works on one pixel at a time; in_stall_o stays high from the
//   accepted transfer until the result has moved into the output register.
//   Steps: the scale is taken from a reciprocal multiply, then two
//   divisions (the two coordinates, on one shared bit-serial divider),
//   then the iteration run, with three products per iteration on the
//   shared multiplier, which walks the FRAC_BITS+4 bit operand in NCH
//   chunks of at most 32 bits.
//   A finished result waiting in the output register does not keep the
//   block from taking the next pixel; while out_stall_i holds it, the next
//   result waits in the final state and the input channel stays stalled.
//   Reset clears the handshake state, sets the frame to 2000 x 2000 and
//   the iteration limit to 100. The user must write the configuration
//   registers only while no pixel is in flight; the block does not check this.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  // Pixel channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire pixel_t                   in_data_i,
  // Result channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output result_t                       out_data_o
);

  localparam int CB  = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int VAL = F + 8;
  localparam int MW  = F + 4;
  localparam int PW  = F + 5;
  localparam int ZW  = F + 10;
  localparam int DVD = CB + 1 + F;
  localparam int DVS = CB + 1;
  localparam int QW  = (DVD > VAL) ? DVD : VAL;

  // floor(x / 10) = (x * 52429) >> 19, exact for every x below 2^16.
  localparam int                    TENTH_SHIFT = 19;
  localparam logic [15:0]           TENTH_MUL   = 16'd52429;
  localparam logic [QW-1:0]         SAT_LIM  = QW'(1) << (VAL - 1);
  localparam logic signed [VAL-1:0] SAT_NEG  = {1'b1, {(VAL-1){1'b0}}};
  localparam logic signed [VAL-1:0] SAT_POS  = {1'b0, {(VAL-1){1'b1}}};
  localparam logic signed [ZW-1:0]  TWO_FX   = ZW'(2) <<< F;
  localparam logic signed [ZW-1:0]  NTWO_FX  = -TWO_FX;
  localparam logic signed [ZW-1:0]  FOUR_FX  = ZW'(4) <<< F;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCALE = 7'b0000010,
    S_MAPR  = 7'b0000100,
    S_MAPI  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_EVAL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    OP_SQR   = 2'd0,
    OP_SQI   = 2'd1,
    OP_XPROD = 2'd2
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d, op_issue, op_next;

  logic [CB-1:0]          width_q, height_q;
  logic [LIMIT_BITS-1:0]  limit_q;
  logic [CB-1:0]          col_q, col_d, row_q, row_d, scale_q, scale_d, scale_new;
  logic signed [VAL-1:0]  cr_q, cr_d, ci_q, ci_d, c_val;
  logic signed [MW-1:0]   zr_q, zr_d, zi_q, zi_d;
  logic signed [PW-1:0]   sqr_q, sqr_d, sqi_q, sqi_d, xprod_q, xprod_d;
  logic [LIMIT_BITS-1:0]  k_q, k_d;
  logic                   issue_q, issue_d;
  logic                   res_esc_q, res_esc_d;
  logic [COUNT_BITS-1:0]  res_cnt_q, res_cnt_d;
  logic                   out_valid_q;
  result_t                out_data_q;

  logic                   in_accept, out_load;
  logic [CB:0]            sum_wh;
  logic [TENTH_SHIFT+CB-1:0] scale_prod;
  logic [CB-1:0]          scale_quo;
  logic signed [CB+1:0]   row_num, col_num, row_abs, col_abs;
  logic [CB:0]            row_mag, col_mag;
  logic                   c_neg, c_sat;
  logic [QW-1:0]          quo_x;

  logic                   div_start, div_done;
  logic [DVD-1:0]         div_dvd, div_quo;
  logic [DVS-1:0]         div_dvs;

  logic                   mul_start, mul_done;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   mul_res;

  logic signed [ZW-1:0]   sqr_x, sqi_x, xprod_x, cr_x, ci_x, sq_sum, nr, ni;
  logic                   test_esc, range_esc;
  logic [COUNT_BITS-1:0]  k_inc1, k_inc2;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      limit_q  <= ITERATION_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:     width_q  <= cfg_data_i[CB-1:0];
        REG_FRAME_HEIGHT:    height_q <= cfg_data_i[CB-1:0];
        REG_ITERATION_LIMIT: limit_q  <= cfg_data_i[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Coordinate mapping: numerator 2*pos - extent and its magnitude.
  assign sum_wh  = {1'b0, width_q} + {1'b0, height_q};
  assign row_num = $signed({1'b0, row_q, 1'b0}) - $signed({2'b00, height_q});
  assign col_num = $signed({1'b0, col_q, 1'b0}) - $signed({2'b00, width_q});
  assign row_abs = row_num[CB+1] ? -row_num : row_num;
  assign col_abs = col_num[CB+1] ? -col_num : col_num;
  assign row_mag = row_abs[CB:0];
  assign col_mag = col_abs[CB:0];

  // Scale is the frame sum over ten by a reciprocal multiply, clamped to at least one.
  assign scale_prod = sum_wh * TENTH_MUL;
  assign scale_quo  = scale_prod[TENTH_SHIFT +: CB];
  assign scale_new  = (scale_quo == '0) ? CB'(1) : scale_quo;

  // Signed, saturated constant from the quotient magnitude.
  assign c_neg = (state_q == S_MAPR) ? row_num[CB+1] : col_num[CB+1];
  assign quo_x = QW'(div_quo);
  assign c_sat = (quo_x >= SAT_LIM);
  always_comb begin
    if (c_neg) begin
      c_val = c_sat ? SAT_NEG : VAL'(0) - $signed(quo_x[VAL-1:0]);
    end else begin
      c_val = c_sat ? SAT_POS : $signed(quo_x[VAL-1:0]);
    end
  end

  // Iteration arithmetic on the current z and its products.
  assign sqr_x     = ZW'(sqr_q);
  assign sqi_x     = ZW'(sqi_q);
  assign xprod_x   = ZW'(xprod_q);
  assign cr_x      = ZW'(cr_q);
  assign ci_x      = ZW'(ci_q);
  assign sq_sum    = sqr_x + sqi_x;
  assign test_esc  = (sq_sum > FOUR_FX);
  assign nr        = sqr_x - sqi_x + cr_x;
  assign ni        = xprod_x + ci_x;
  assign range_esc = (nr > TWO_FX) || (nr < NTWO_FX) || (ni > TWO_FX) || (ni < NTWO_FX);
  assign k_inc1    = {1'b0, k_q} + COUNT_BITS'(1);
  assign k_inc2    = {1'b0, k_q} + COUNT_BITS'(2);

  // Product order within one iteration.
  always_comb begin
    unique case (op_q)
      OP_SQR:  op_next = OP_SQI;
      OP_SQI:  op_next = OP_XPROD;
      default: op_next = OP_XPROD;
    endcase
  end

  // Multiplier operands for the product being issued.
  always_comb begin
    unique case (op_issue)
      OP_SQR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      OP_SQI: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q <<< 1;
        mul_b = zi_q;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    op_issue  = op_q;
    issue_d   = 1'b0;
    col_d     = col_q;
    row_d     = row_q;
    scale_d   = scale_q;
    cr_d      = cr_q;
    ci_d      = ci_q;
    zr_d      = zr_q;
    zi_d      = zi_q;
    sqr_d     = sqr_q;
    sqi_d     = sqi_q;
    xprod_d   = xprod_q;
    k_d       = k_q;
    res_esc_d = res_esc_q;
    res_cnt_d = res_cnt_q;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    mul_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          col_d     = in_data_i.pixel_col;
          row_d     = in_data_i.pixel_row;
          state_d   = S_SCALE;
        end
      end
      S_SCALE: begin
        scale_d   = scale_new;
        div_start = 1'b1;
        div_dvd   = {row_mag, {F{1'b0}}};
        div_dvs   = {scale_new, 1'b0};
        state_d   = S_MAPR;
      end
      S_MAPR: begin
        if (div_done) begin
          cr_d      = c_val;
          div_start = 1'b1;
          div_dvd   = {col_mag, {F{1'b0}}};
          div_dvs   = {scale_q, 1'b0};
          state_d   = S_MAPI;
        end
      end
      S_MAPI: begin
        if (div_done) begin
          ci_d    = c_val;
          zr_d    = '0;
          zi_d    = '0;
          sqr_d   = '0;
          sqi_d   = '0;
          xprod_d = '0;
          k_d     = '0;
          state_d = S_EVAL;
        end
      end
      S_MUL: begin
        if (issue_q) begin
          mul_start = 1'b1;
        end else if (mul_done) begin
          unique case (op_q)
            OP_SQR:  sqr_d   = mul_res;
            OP_SQI:  sqi_d   = mul_res;
            default: xprod_d = mul_res;
          endcase
          if (op_q == OP_XPROD) begin
            state_d = S_EVAL;
          end else begin
            op_d      = op_next;
            op_issue  = op_next;
            mul_start = 1'b1;
          end
        end
      end
      S_EVAL: begin
        // Squares test of the current z, then the limit, then the new z.
        if (test_esc) begin
          res_esc_d = 1'b1;
          res_cnt_d = k_inc1;
          state_d   = S_DONE;
        end else if (k_q == limit_q) begin
          res_esc_d = 1'b0;
          res_cnt_d = '0;
          state_d   = S_DONE;
        end else if (range_esc) begin
          res_esc_d = 1'b1;
          res_cnt_d = k_inc2;
          state_d   = S_DONE;
        end else begin
          zr_d    = nr[MW-1:0];
          zi_d    = ni[MW-1:0];
          k_d     = k_q + LIMIT_BITS'(1);
          op_d    = OP_SQR;
          issue_d = 1'b1;
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_SQR;
      issue_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      issue_q <= issue_d;
      k_q     <= k_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    col_q     <= col_d;
    row_q     <= row_d;
    scale_q   <= scale_d;
    cr_q      <= cr_d;
    ci_q      <= ci_d;
    zr_q      <= zr_d;
    zi_q      <= zi_d;
    sqr_q     <= sqr_d;
    sqi_q     <= sqi_d;
    xprod_q   <= xprod_d;
    res_esc_q <= res_esc_d;
    res_cnt_q <= res_cnt_d;
  end

  // Output register: a result transfer frees it, a finished pixel refills it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.escaped      <= res_esc_q;
      out_data_q.escape_count <= res_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Shared divider for both coordinates.
  mbe_div #(
    .DVD_BITS (DVD),
    .DVS_BITS (DVS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Shared multiplier for the squares and the cross term.
  mbe_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

endmodule

`default_nettype wire

>>> sv/mbe_div.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_div import mbe_pkg::*; #(
  parameter int DVD_BITS = DIV_DVD_BITS_DEF,
  parameter int DVS_BITS = DIV_DVS_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DVD_BITS-1:0] dividend_i,
  input  wire logic [DVS_BITS-1:0] divisor_i,
  output logic                     done_o,
  output logic      [DVD_BITS-1:0] quotient_o
);

  localparam int CNT_BITS = $clog2(DVD_BITS);

  logic [DVD_BITS-1:0] quo_q;
  logic [DVS_BITS-1:0] rem_q, dvs_q, rem_d;
  logic [CNT_BITS-1:0] cnt_q;
  logic                busy_q, done_q, last;
  logic [DVS_BITS:0]   trial, diff;
  logic                ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, quo_q[DVD_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});
  assign rem_d = ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
  assign last  = (cnt_q == CNT_BITS'(DVD_BITS - 1));

  // Control: busy for one cycle per dividend bit, then a one-cycle done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills up with quotient bits from the right.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_BITS-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> sv/mbe_mul.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time multiplier
// Signed fixed-point multiplier that walks the second operand in chunks of
// at most 32 bits, most significant chunk first, and returns the product
// floored to the fraction width.
// ----------------------------------------------------------------------------
`default_nettype none

module mbe_mul import mbe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic signed [FRAC_BITS+3:0] a_i,
  input  wire logic signed [FRAC_BITS+3:0] b_i,
  output logic                             done_o,
  output logic signed      [FRAC_BITS+4:0] result_o
);

  localparam int MW       = FRAC_BITS + 4;
  localparam int PW       = FRAC_BITS + 5;
  localparam int NCH      = (MW + 31) / 32;
  localparam int CW       = (MW + NCH - 1) / NCH;
  localparam int BW       = NCH * CW;
  localparam int AW       = MW + BW + 1;
  localparam int CNT_BITS = $clog2(NCH + 1);

  logic signed [MW-1:0]   a_q, a_cur;
  logic        [BW-1:0]   bsh_q, b_cur, b_ext;
  logic        [CW-1:0]   chunk;
  logic signed [CW:0]     chunk_s;
  logic signed [MW+CW:0]  pp;
  logic signed [AW-1:0]   pp_ext, acc_q, acc_d;
  logic [CNT_BITS-1:0]    cnt_q, idx;
  logic                   busy_q, done_q, step, last;

  // Operand selection: the first chunk comes straight from the inputs.
  assign b_ext   = BW'(b_i);
  assign a_cur   = start_i ? a_i : a_q;
  assign b_cur   = start_i ? b_ext : bsh_q;
  assign chunk   = b_cur[BW-1 -: CW];
  assign chunk_s = start_i ? $signed({chunk[CW-1], chunk}) : $signed({1'b0, chunk});

  // One partial product per cycle, accumulated with a fixed left shift.
  assign pp     = a_cur * chunk_s;
  assign pp_ext = AW'(pp);
  assign acc_d  = start_i ? pp_ext : (acc_q <<< CW) + pp_ext;

  assign step = start_i || busy_q;
  assign idx  = start_i ? '0 : cnt_q;
  assign last = (idx == CNT_BITS'(NCH - 1));

  // Chunk sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= step && !last;
      done_q <= step && last;
      if (step) begin
        cnt_q <= idx + CNT_BITS'(1);
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
    end
    if (step) begin
      acc_q <= acc_d;
      bsh_q <= b_cur << CW;
    end
  end

  // Arithmetic shift right of the full product rounds toward minus infinity.
  assign done_o   = done_q;
  assign result_o = acc_q[FRAC_BITS +: PW];

endmodule

`default_nettype wire
